/* sv/pled_pkg.sv */
// Shared types, tail tables and step limits for the PWM LED chaser.
package pled_pkg;

	localparam int DUTY_W = 7;
	localparam int TAIL_LEN = 8;

	localparam logic [3:0] STEPS_RIGHT = 4'd9;
	localparam logic [3:0] STEPS_LEFT = 4'd9;
	localparam logic [3:0] STEPS_CONV = 4'd15;

	localparam logic [7:0] PERIOD_RESET = 8'd100;
	localparam logic [7:0] FRAMES_RESET = 8'd4;

	localparam logic CFG_PERIOD = 1'b0;
	localparam logic CFG_FRAMES = 1'b1;

	typedef logic [DUTY_W-1:0] duty_t;

	typedef enum logic [1:0] {
		PH_RIGHT = 2'd0,
		PH_LEFT  = 2'd1,
		PH_CONV  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		OP_HOLD   = 3'd0,
		OP_ROT_R  = 3'd1,
		OP_ROT_L  = 3'd2,
		OP_CONV   = 3'd3,
		OP_LOAD_R = 3'd4,
		OP_LOAD_L = 3'd5,
		OP_LOAD_C = 3'd6
	} strip_op_t;

	localparam duty_t TAIL_LEFT [TAIL_LEN] = '{
		7'd100, 7'd50, 7'd25, 7'd12, 7'd6, 7'd3, 7'd1, 7'd0
	};
	localparam duty_t TAIL_RIGHT [TAIL_LEN] = '{
		7'd0, 7'd1, 7'd3, 7'd6, 7'd12, 7'd25, 7'd50, 7'd100
	};

	// Tail value at strip position pos, tail sitting in the last TAIL_LEN entries.
	function automatic duty_t tail_at(input logic right_tail, input int pos, input int len);
		int k;
		duty_t v;
		k = pos - (len - TAIL_LEN);
		v = '0;
		if (k >= 0 && k < TAIL_LEN) begin
			v = right_tail ? TAIL_RIGHT[k] : TAIL_LEFT[k];
		end
		return v;
	endfunction

endpackage

/* sv/pled_cell.sv */
// One strip cell: holds one duty, left and right entry and shifts with its neighbors.
module pled_cell #(
	parameter logic [6:0] RIGHT_PREV = 7'd0,
	parameter logic [6:0] LEFT_NEXT = 7'd0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pled_pkg::strip_op_t op,
	input  pled_pkg::duty_t     duty_prev,
	input  pled_pkg::duty_t     duty_next,
	input  pled_pkg::duty_t     left_next,
	input  pled_pkg::duty_t     right_prev,
	output pled_pkg::duty_t     duty,
	output pled_pkg::duty_t     left,
	output pled_pkg::duty_t     right
);

	pled_pkg::duty_t duty_q, left_q, right_q;
	pled_pkg::duty_t duty_d, left_d, right_d;

	always_comb begin
		duty_d = duty_q;
		left_d = left_q;
		right_d = right_q;
		case (op)
			pled_pkg::OP_HOLD: begin
			end
			pled_pkg::OP_ROT_R: duty_d = duty_prev;
			pled_pkg::OP_ROT_L: duty_d = duty_next;
			pled_pkg::OP_CONV: begin
				left_d = left_next;
				right_d = right_prev;
				duty_d = (left_next > right_prev) ? left_next : right_prev;
			end
			pled_pkg::OP_LOAD_R: duty_d = RIGHT_PREV;
			pled_pkg::OP_LOAD_L: duty_d = LEFT_NEXT;
			pled_pkg::OP_LOAD_C: begin
				left_d = LEFT_NEXT;
				right_d = RIGHT_PREV;
				duty_d = (LEFT_NEXT > RIGHT_PREV) ? LEFT_NEXT : RIGHT_PREV;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= RIGHT_PREV;
			left_q <= '0;
			right_q <= '0;
		end else begin
			duty_q <= duty_d;
			left_q <= left_d;
			right_q <= right_d;
		end
	end

	assign duty = duty_q;
	assign left = left_q;
	assign right = right_q;

endmodule

/* sv/pled_seq.sv */
// PWM, frame and step counters with the phase sequencer that drives the strip.
module pled_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          pwm_period,
	input  logic [7:0]          frames_per_step,
	output logic [7:0]          pwm_count,
	output pled_pkg::phase_t    phase,
	output logic [3:0]          step,
	output pled_pkg::strip_op_t op
);

	logic [7:0]       pwm_q, frame_q, pwm_d, frame_d;
	logic [3:0]       step_q, step_d, limit;
	pled_pkg::phase_t phase_q, phase_d;
	logic [8:0]       pwm_inc, frame_inc;
	logic [4:0]       step_inc;

	always_comb begin
		pwm_inc = {1'b0, pwm_q} + 9'd1;
		frame_inc = {1'b0, frame_q} + 9'd1;
		step_inc = {1'b0, step_q} + 5'd1;
		pwm_d = pwm_q;
		frame_d = frame_q;
		step_d = step_q;
		phase_d = phase_q;
		op = pled_pkg::OP_HOLD;
		case (phase_q)
			pled_pkg::PH_RIGHT: limit = pled_pkg::STEPS_RIGHT;
			pled_pkg::PH_LEFT:  limit = pled_pkg::STEPS_LEFT;
			default:            limit = pled_pkg::STEPS_CONV;
		endcase
		if (advance) begin
			if (pwm_inc >= {1'b0, pwm_period}) begin
				pwm_d = '0;
				if (frame_inc >= {1'b0, frames_per_step}) begin
					frame_d = '0;
					if (step_inc < {1'b0, limit}) begin
						// advance within the phase
						step_d = step_inc[3:0];
						case (phase_q)
							pled_pkg::PH_RIGHT: op = pled_pkg::OP_ROT_R;
							pled_pkg::PH_LEFT:  op = pled_pkg::OP_ROT_L;
							default:            op = pled_pkg::OP_CONV;
						endcase
					end else begin
						// enter the next phase with its first step applied
						step_d = '0;
						case (phase_q)
							pled_pkg::PH_RIGHT: begin
								phase_d = pled_pkg::PH_LEFT;
								op = pled_pkg::OP_LOAD_L;
							end
							pled_pkg::PH_LEFT: begin
								phase_d = pled_pkg::PH_CONV;
								op = pled_pkg::OP_LOAD_C;
							end
							default: begin
								phase_d = pled_pkg::PH_RIGHT;
								op = pled_pkg::OP_LOAD_R;
							end
						endcase
					end
				end else begin
					frame_d = frame_inc[7:0];
				end
			end else begin
				pwm_d = pwm_inc[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_q <= '0;
			frame_q <= '0;
			step_q <= '0;
			phase_q <= pled_pkg::PH_RIGHT;
		end else begin
			pwm_q <= pwm_d;
			frame_q <= frame_d;
			step_q <= step_d;
			phase_q <= phase_d;
		end
	end

	assign pwm_count = pwm_q;
	assign phase = phase_q;
	assign step = step_q;

endmodule

/* sv/pwm_led_chaser_with_tails.sv */
// Top level of the PWM LED chaser: counters, a row of strip cells and the output register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, tick_enable           | beat in
//  out     | out_valid, out_stall, led_port,           | beat out
//          | phase_now, step_now                       |
//  cfg     | cfg_we, cfg_index, cfg_data               | write only
//
// One beat per clock unless stalled: each accepted input beat yields its result in the
// next cycle from the output register, and the counters and the cell row advance in that
// same cycle when tick_enable is set. The single output register sets the latency; the
// input is stalled only while that register holds a result that the output side stalls.
// Reset clears the counters, loads the right tail rotated right once into the cells
// and restores both configuration registers to their defaults.
module pwm_led_chaser_with_tails #(
	parameter int STRIP_LENGTH = 16,
	parameter int LED_COUNT = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       tick_enable,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] led_port,
	output logic [1:0] phase_now,
	output logic [3:0] step_now,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int PORT_BITS = 8;

	logic [7:0]          period_q, frames_q;
	logic                in_accept, advance;
	logic [7:0]          pwm_count;
	pled_pkg::phase_t    phase;
	logic [3:0]          step;
	pled_pkg::strip_op_t op;
	logic [PORT_BITS-1:0] port_d;

	pled_pkg::duty_t duty_w [STRIP_LENGTH];
	pled_pkg::duty_t left_w [STRIP_LENGTH];
	pled_pkg::duty_t right_w [STRIP_LENGTH];

	logic             out_valid_q;
	logic [7:0]       led_port_q;
	logic [1:0]       phase_now_q;
	logic [3:0]       step_now_q;

	// Configuration registers; the user must write them only while idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= pled_pkg::PERIOD_RESET;
			frames_q <= pled_pkg::FRAMES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pled_pkg::CFG_PERIOD: period_q <= cfg_data;
				pled_pkg::CFG_FRAMES: frames_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Stall input only when the result register is full and held.
	assign in_stall = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;
	assign advance = in_accept && tick_enable;

	pled_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.pwm_period      (period_q),
		.frames_per_step (frames_q),
		.pwm_count       (pwm_count),
		.phase           (phase),
		.step            (step),
		.op              (op)
	);

	// Ring of cells: each sees its left and right neighbor, wrapping at the ends.
	for (genvar i = 0; i < STRIP_LENGTH; i++) begin : g_cell
		localparam int PREV = (i + STRIP_LENGTH - 1) % STRIP_LENGTH;
		localparam int NEXT = (i + 1) % STRIP_LENGTH;
		pled_cell #(
			.RIGHT_PREV (pled_pkg::tail_at(1'b1, PREV, STRIP_LENGTH)),
			.LEFT_NEXT  (pled_pkg::tail_at(1'b0, NEXT, STRIP_LENGTH))
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.duty_prev  (duty_w[PREV]),
			.duty_next  (duty_w[NEXT]),
			.left_next  (left_w[NEXT]),
			.right_prev (right_w[PREV]),
			.duty       (duty_w[i]),
			.left       (left_w[i]),
			.right      (right_w[i])
		);
	end

	// Port bit set means LED off: count at or above that cell's duty.
	for (genvar j = 0; j < PORT_BITS; j++) begin : g_port
		if (j < LED_COUNT && j < STRIP_LENGTH) begin : g_on
			assign port_d[j] = pwm_count >= {1'b0, duty_w[j]};
		end else begin : g_off
			assign port_d[j] = 1'b0;
		end
	end

	// Capture the pre-tick view on accept; drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			led_port_q <= port_d;
			phase_now_q <= phase;
			step_now_q <= step;
		end
	end

	assign out_valid = out_valid_q;
	assign led_port = led_port_q;
	assign phase_now = phase_now_q;
	assign step_now = step_now_q;

endmodule

/* sv/pled_chk.sv */
// Port-level checker for the PWM LED chaser, bound to the top level.
module pled_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] phase_now,
	input logic [3:0] step_now
);

	// Input stalls exactly when a result is held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow held result");

	// Every accepted beat shows a result next cycle.
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted beat gave no result");

	// A held result stays until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(phase_now) && $stable(step_now)))
		else $error("stalled result changed");

	// Step stays inside its phase's range.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			((phase_now == pled_pkg::PH_RIGHT && step_now < pled_pkg::STEPS_RIGHT) ||
			(phase_now == pled_pkg::PH_LEFT && step_now < pled_pkg::STEPS_LEFT) ||
			(phase_now == pled_pkg::PH_CONV && step_now < pled_pkg::STEPS_CONV)))
		else $error("phase or step out of range");

endmodule

bind pwm_led_chaser_with_tails pled_chk u_pled_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.phase_now (phase_now),
	.step_now  (step_now)
);
